FILE: rtl/srpr_pkg.sv
// shared types and constants for the screen rectangle pointer router
// depends on nothing; used by every module of the block
`default_nettype none

package srpr_pkg;

	localparam int COORD_W = 16;
	// wide enough for every sum, difference and distance of 16-bit coordinates
	localparam int KEY_W   = 18;
	// slot tag carried down the chain, covers the largest table size
	localparam int SLOT_W  = 6;

	typedef enum logic [2:0] {
		REQ_CLEAR    = 3'd0,
		REQ_WRITE    = 3'd1,
		REQ_CONTAIN  = 3'd2,
		REQ_NEIGHBOR = 3'd3,
		REQ_WRAP     = 3'd4
	} req_kind_t;

	typedef enum logic [1:0] {
		DIR_TOP    = 2'd0,
		DIR_LEFT   = 2'd1,
		DIR_BOTTOM = 2'd2,
		DIR_RIGHT  = 2'd3
	} dir_t;

	// how a qualifying slot competes with the best so far
	typedef enum logic [1:0] {
		RULE_FIRST = 2'd0,
		RULE_LE    = 2'd1,
		RULE_GT    = 2'd2,
		RULE_LT    = 2'd3
	} rule_t;

	typedef struct packed {
		logic [2:0]                 req_type;
		logic [2:0]                 slot_index;
		logic signed [COORD_W-1:0]  rect_left;
		logic signed [COORD_W-1:0]  rect_top;
		logic [COORD_W-1:0]         rect_wide;
		logic [COORD_W-1:0]         rect_tall;
		logic signed [COORD_W-1:0]  pointer_x;
		logic signed [COORD_W-1:0]  pointer_y;
		logic [1:0]                 direction;
	} item_t;

	typedef struct packed {
		logic       found;
		logic [2:0] result_slot;
	} result_t;

	typedef struct packed {
		req_kind_t                  kind;
		dir_t                       dir;
		rule_t                      rule;
		logic signed [COORD_W-1:0]  px;
		logic signed [COORD_W-1:0]  py;
	} query_t;

	// stored rectangle with its far edges precomputed
	typedef struct packed {
		logic                       valid;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [KEY_W-1:0]    xe;
		logic signed [KEY_W-1:0]    ye;
	} rect_view_t;

	// running best handed from cell to cell
	typedef struct packed {
		logic                     live;
		logic                     found;
		logic [SLOT_W-1:0]        slot;
		logic signed [KEY_W-1:0]  key;
	} token_t;

endpackage

`default_nettype wire

FILE: rtl/srpr_cell.sv
// one table slot: stored rectangle, local match evaluation, one chain step
// depends on srpr_pkg
`default_nettype none

module srpr_cell #(
	parameter int CELL_ID = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic                clr,
	input  wire srpr_pkg::item_t     wr_data,
	input  wire srpr_pkg::query_t    qry,
	input  wire srpr_pkg::rect_view_t src,
	input  wire logic                src_ok,
	input  wire srpr_pkg::token_t    tok_in,
	output srpr_pkg::token_t         tok_out,
	output srpr_pkg::rect_view_t     view
);
	import srpr_pkg::*;

	logic                       valid_q;
	logic signed [COORD_W-1:0]  x_q;
	logic signed [COORD_W-1:0]  y_q;
	logic signed [KEY_W-1:0]    xe_q;
	logic signed [KEY_W-1:0]    ye_q;

	logic signed [KEY_W-1:0]    px_w, py_w, x_w, y_w, sx_w, sy_w;
	logic                       in_h, in_v, touch, qual;
	logic signed [KEY_W-1:0]    d0, d1;
	logic                       qual_s1;
	logic signed [KEY_W-1:0]    d0_s1, d1_s1;
	logic signed [KEY_W-1:0]    a0, a1, key;
	logic                       qual_s2;
	logic signed [KEY_W-1:0]    key_s2;
	logic                       better, take;
	token_t                     nxt;
	logic                       live_q;
	token_t                     data_q;

	// slot storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_q  <= wr_data.rect_left;
			y_q  <= wr_data.rect_top;
			xe_q <= {{(KEY_W-COORD_W){wr_data.rect_left[COORD_W-1]}}, wr_data.rect_left}
				+ {{(KEY_W-COORD_W){1'b0}}, wr_data.rect_wide};
			ye_q <= {{(KEY_W-COORD_W){wr_data.rect_top[COORD_W-1]}}, wr_data.rect_top}
				+ {{(KEY_W-COORD_W){1'b0}}, wr_data.rect_tall};
		end
	end

	assign view = '{valid: valid_q, x: x_q, y: y_q, xe: xe_q, ye: ye_q};

	assign px_w = {{(KEY_W-COORD_W){qry.px[COORD_W-1]}}, qry.px};
	assign py_w = {{(KEY_W-COORD_W){qry.py[COORD_W-1]}}, qry.py};
	assign x_w  = {{(KEY_W-COORD_W){x_q[COORD_W-1]}}, x_q};
	assign y_w  = {{(KEY_W-COORD_W){y_q[COORD_W-1]}}, y_q};
	assign sx_w = {{(KEY_W-COORD_W){src.x[COORD_W-1]}}, src.x};
	assign sy_w = {{(KEY_W-COORD_W){src.y[COORD_W-1]}}, src.y};

	// first stage: containment, touching test and raw differences
	always_comb begin
		in_h = (px_w >= x_w) && (px_w < xe_q);
		in_v = (py_w >= y_w) && (py_w < ye_q);
		unique case (qry.dir)
			DIR_TOP: begin
				touch = (ye_q == sy_w);
				d0    = ye_q;
			end
			DIR_LEFT: begin
				touch = (xe_q == sx_w);
				d0    = xe_q;
			end
			DIR_BOTTOM: begin
				touch = (src.ye == y_w);
				d0    = y_w;
			end
			DIR_RIGHT: begin
				touch = (src.xe == x_w);
				d0    = x_w;
			end
		endcase
		d1 = d0;
		unique case (qry.kind)
			REQ_CONTAIN: begin
				qual = valid_q && in_h && in_v;
			end
			REQ_NEIGHBOR: begin
				qual = src_ok && valid_q && touch;
				// distance to the near and far edge along the shared side
				if (qry.dir == DIR_TOP || qry.dir == DIR_BOTTOM) begin
					d0 = px_w - x_w;
					d1 = px_w - xe_q + KEY_W'(1);
				end else begin
					d0 = py_w - y_w;
					d1 = py_w - ye_q;
				end
			end
			REQ_WRAP: begin
				if (qry.dir == DIR_TOP || qry.dir == DIR_BOTTOM) begin
					qual = valid_q && in_h;
				end else begin
					qual = valid_q && in_v;
				end
			end
			default: begin
				qual = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		qual_s1 <= qual;
		d0_s1   <= d0;
		d1_s1   <= d1;
	end

	// second stage: edge metric for neighbor picks, plain key otherwise
	always_comb begin
		a0  = d0_s1[KEY_W-1] ? -d0_s1 : d0_s1;
		a1  = d1_s1[KEY_W-1] ? -d1_s1 : d1_s1;
		key = d0_s1;
		if (qry.kind == REQ_NEIGHBOR) begin
			key = (a1 < a0) ? a1 : a0;
		end
	end

	always_ff @(posedge clk) begin
		qual_s2 <= qual_s1;
		key_s2  <= key;
	end

	// chain step: compete with the running best
	always_comb begin
		unique case (qry.rule)
			RULE_FIRST: better = 1'b0;
			RULE_LE:    better = (key_s2 <= tok_in.key);
			RULE_GT:    better = (key_s2 > tok_in.key);
			RULE_LT:    better = (key_s2 < tok_in.key);
		endcase
		take        = tok_in.live && qual_s2 && (!tok_in.found || better);
		nxt.live    = tok_in.live;
		nxt.found   = tok_in.found || take;
		nxt.slot    = take ? SLOT_W'(CELL_ID) : tok_in.slot;
		nxt.key     = take ? key_s2 : tok_in.key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else begin
			live_q <= nxt.live;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign tok_out = '{live: live_q, found: data_q.found, slot: data_q.slot, key: data_q.key};

endmodule

`default_nettype wire

FILE: rtl/screen_rect_pointer_router_unit.sv
// top level of the screen rectangle pointer router: request capture, source
// lookup and the row of slot cells; depends on srpr_pkg and srpr_cell
// writes and clears take effect at the accept edge; every request answers
//   with one done pulse, after the best-so-far token has walked the cell row
//   one slot per cycle; the block takes no new request until that pulse
// busy drops in the done cycle, so the next start can transfer there
// reset clears every valid bit and the control state at once; no sweep
`default_nettype none

module screen_rect_pointer_router_unit #(
	parameter int MAX_RECTS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire srpr_pkg::item_t   item,
	output logic                   done,
	output srpr_pkg::result_t      result
);
	import srpr_pkg::*;

	localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

	logic          accept;
	logic          busy_q;
	logic [2:0]    ph_q;        // one-hot walk through capture, lookup, evaluate
	logic          launch_q;
	item_t         q_q;         // request held for the whole scan
	query_t        qry;
	rect_view_t    src_q;
	logic          src_ok_q;
	logic [IW-1:0] src_sel;
	logic          src_in_range;
	logic          clr;

	rect_view_t    cell_view [MAX_RECTS];
	logic          wr_en     [MAX_RECTS];
	token_t        tok       [MAX_RECTS+1];

	assign accept = start && !busy;
	assign done   = tok[MAX_RECTS].live;
	assign busy   = busy_q && !done;

	// control: busy from transfer to result, phase walk starts the token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ph_q     <= '0;
			launch_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			ph_q     <= {ph_q[1:0], accept};
			launch_q <= ph_q[2];
		end
	end

	// held request starts out as a harmless clear so the decode is never unknown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= '0;
		end else if (accept) begin
			q_q <= item;
		end
	end

	// query broadcast, with the compare rule picked once for all cells
	always_comb begin
		qry.kind = req_kind_t'(q_q.req_type);
		qry.dir  = dir_t'(q_q.direction);
		qry.px   = q_q.pointer_x;
		qry.py   = q_q.pointer_y;
		unique case (qry.kind)
			REQ_NEIGHBOR: begin
				// ties go to the later slot
				qry.rule = RULE_LE;
			end
			REQ_WRAP: begin
				// top and left keep the far edge, bottom and right the near one
				if (qry.dir == DIR_TOP || qry.dir == DIR_LEFT) begin
					qry.rule = RULE_GT;
				end else begin
					qry.rule = RULE_LT;
				end
			end
			default: begin
				qry.rule = RULE_FIRST;
			end
		endcase
	end

	// source rectangle for neighbor picks, read in the cycle after the transfer
	assign src_sel      = IW'(q_q.slot_index);
	assign src_in_range = (int'(q_q.slot_index) < MAX_RECTS);

	always_ff @(posedge clk) begin
		src_q    <= cell_view[src_sel];
		src_ok_q <= src_in_range && cell_view[src_sel].valid;
	end

	assign clr = accept && (item.req_type == REQ_CLEAR);

	// empty token enters the row after the two evaluation stages settle
	assign tok[0] = '{live: launch_q, found: 1'b0, slot: '0, key: '0};

	for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
		// only slots reachable by the 3-bit index can be written
		assign wr_en[i] = accept && (item.req_type == REQ_WRITE)
			&& (i < (1 << $bits(item.slot_index)))
			&& (item.slot_index == 3'(i));

		srpr_cell #(
			.CELL_ID (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en[i]),
			.clr     (clr),
			.wr_data (item),
			.qry     (qry),
			.src     (src_q),
			.src_ok  (src_ok_q),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.view    (cell_view[i])
		);
	end

	// slot is left at zero by the cells unless a match was taken
	assign result.found       = tok[MAX_RECTS].found;
	assign result.result_slot = tok[MAX_RECTS].slot[2:0];

endmodule

`default_nettype wire

FILE: rtl/srpr_checker.sv
// port-level checks for the screen rectangle pointer router, bound to the top
// depends on srpr_pkg and screen_rect_pointer_router_unit
`default_nettype none

module srpr_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic              done,
	input  wire srpr_pkg::result_t result
);

	// a transfer keeps the block busy on the following cycle
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after transfer");

	// no result in the cycle right after a transfer
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result too early");

	// one result per request: never two strobes in a row
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("repeated result strobe");

	// the block is free again while its result is shown
	a_free_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy during result");

	// a miss reports slot zero
	a_miss_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.result_slot == 3'd0)
		else $error("nonzero slot on miss");

endmodule

bind screen_rect_pointer_router_unit srpr_checker u_srpr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire

FILE: tb/sv/screen_rect_pointer_router_unit_tb.sv
// testbench for screen_rect_pointer_router_unit: tiled rectangle layouts and queries,
// answers checked against a behavioral copy of the rectangle table
// depends on srpr_pkg and the rtl of the block only
`timescale 1ns / 1ps

module screen_rect_pointer_router_unit_tb;

	import srpr_pkg::*;

	localparam int MAX_RECTS     = 8;
	localparam int RANDOM_ITEMS  = 1900;
	localparam int ANSWER_DEPTH  = 16;
	localparam int SETTLE_CYCLES = 3 * (MAX_RECTS + 4);
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int REPORT_LIMIT  = 10;

	// request kinds the block has no use for
	localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

	typedef struct {
		int x;
		int y;
		int w;
		int h;
	} box_t;

	typedef struct packed {
		logic  drain_first;
		item_t payload;
	} pending_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	// shadow copy of the rectangle table
	box_t shadow_box[MAX_RECTS];
	bit   shadow_valid[MAX_RECTS];

	pending_t    stimulus[$];
	result_t     expected_answers[ANSWER_DEPTH];
	int unsigned answers_issued  = 0;
	int unsigned answers_checked = 0;
	int          mismatch_count  = 0;
	int          gap_left        = 0;
	int          burst_left      = 0;
	int          cycle_count     = 0;

	screen_rect_pointer_router_unit #(
		.MAX_RECTS(MAX_RECTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	function automatic int abs_diff(int a, int b);
		return (a > b) ? a - b : b - a;
	endfunction

	// candidate c shares the requested edge of source s
	function automatic bit borders(box_t s, box_t c, logic [1:0] dir);
		case (dir)
			DIR_TOP:    return c.y + c.h == s.y;
			DIR_LEFT:   return c.x + c.w == s.x;
			DIR_BOTTOM: return s.y + s.h == c.y;
			default:    return s.x + s.w == c.x;
		endcase
	endfunction

	// distance from the pointer to the nearer edge; note the asymmetry:
	// the far x edge is x+w-1, the far y edge is y+h
	function automatic int edge_gap(box_t r, logic [1:0] dir, int px, int py);
		int near_d;
		int far_d;
		if (dir == DIR_TOP || dir == DIR_BOTTOM) begin
			near_d = abs_diff(px, r.x);
			far_d  = abs_diff(px, r.x + r.w - 1);
		end else begin
			near_d = abs_diff(py, r.y);
			far_d  = abs_diff(py, r.y + r.h);
		end
		return (near_d < far_d) ? near_d : far_d;
	endfunction

	// applies one request to the shadow table and returns its answer
	function automatic result_t route_answer(item_t it);
		int      px;
		int      py;
		int      m;
		int      bm;
		int      best;
		bit      hit;
		bit      take;
		box_t    src;
		box_t    r;
		box_t    b;
		result_t ans;
		px   = it.pointer_x;
		py   = it.pointer_y;
		hit  = 1'b0;
		best = 0;
		bm   = 0;
		case (it.req_type)
			REQ_CLEAR: begin
				for (int i = 0; i < MAX_RECTS; i++)
					shadow_valid[i] = 1'b0;
			end
			REQ_WRITE: begin
				shadow_box[it.slot_index].x = it.rect_left;
				shadow_box[it.slot_index].y = it.rect_top;
				shadow_box[it.slot_index].w = it.rect_wide;
				shadow_box[it.slot_index].h = it.rect_tall;
				shadow_valid[it.slot_index] = 1'b1;
			end
			REQ_CONTAIN: begin
				for (int i = 0; i < MAX_RECTS; i++) begin
					r = shadow_box[i];
					if (!hit && shadow_valid[i] && px >= r.x && px < r.x + r.w &&
							py >= r.y && py < r.y + r.h) begin
						hit  = 1'b1;
						best = i;
					end
				end
			end
			REQ_NEIGHBOR: begin
				if (shadow_valid[it.slot_index]) begin
					src = shadow_box[it.slot_index];
					for (int i = 0; i < MAX_RECTS; i++) begin
						if (shadow_valid[i] && borders(src, shadow_box[i], it.direction)) begin
							m = edge_gap(shadow_box[i], it.direction, px, py);
							// ties go to the later slot
							if (!hit || !(bm < m)) begin
								hit  = 1'b1;
								best = i;
								bm   = m;
							end
						end
					end
				end
			end
			REQ_WRAP: begin
				for (int i = 0; i < MAX_RECTS; i++) begin
					r = shadow_box[i];
					b = shadow_box[best];
					if (shadow_valid[i]) begin
						if (it.direction == DIR_TOP || it.direction == DIR_BOTTOM) begin
							if (!(r.x + r.w <= px || r.x > px)) begin
								take = !hit ||
									(it.direction == DIR_TOP && r.y + r.h > b.y + b.h) ||
									(it.direction == DIR_BOTTOM && r.y < b.y);
								if (take) begin
									hit  = 1'b1;
									best = i;
								end
							end
						end else begin
							if (!(r.y + r.h <= py || r.y > py)) begin
								take = !hit ||
									(it.direction == DIR_LEFT && r.x + r.w > b.x + b.w) ||
									(it.direction == DIR_RIGHT && r.x < b.x);
								if (take) begin
									hit  = 1'b1;
									best = i;
								end
							end
						end
					end
				end
			end
			default: ;
		endcase
		ans.found       = hit;
		ans.result_slot = hit ? 3'(best) : 3'd0;
		return ans;
	endfunction

	// ---------------------------------------------------------------
	// item builders
	// ---------------------------------------------------------------

	function automatic item_t random_item();
		logic [127:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom};
		return bits[$bits(item_t)-1:0];
	endfunction

	// unused fields carry random junk so every bit toggles
	function automatic item_t make_write(int slot, int x, int y, int w, int h);
		item_t it;
		it            = random_item();
		it.req_type   = REQ_WRITE;
		it.slot_index = 3'(slot);
		it.rect_left  = 16'(x);
		it.rect_top   = 16'(y);
		it.rect_wide  = 16'(w);
		it.rect_tall  = 16'(h);
		return it;
	endfunction

	function automatic item_t make_query(req_kind_t kind, int slot, int px, int py,
			dir_t dir);
		item_t it;
		it            = random_item();
		it.req_type   = kind;
		it.slot_index = 3'(slot);
		it.pointer_x  = 16'(px);
		it.pointer_y  = 16'(py);
		it.direction  = dir;
		return it;
	endfunction

	task automatic queue_item(item_t it, bit drain);
		pending_t p;
		p.drain_first = drain;
		p.payload     = it;
		stimulus.push_back(p);
	endtask

	// idle length after a transfer: mostly none or short, a few long,
	// now and then a back-to-back burst
	function automatic int pick_gap();
		int roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 50)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 13);
		return $urandom_range(14, 40);
	endfunction

	// ---------------------------------------------------------------
	// driver: one transfer when start is high and busy is low
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_requests
		bit taken;
		if (!arst_n) begin
			start          <= 1'b0;
			item           <= '0;
			answers_issued <= 0;
			gap_left        = 0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				// the table changes at the transfer edge, so predict right here
				expected_answers[answers_issued % ANSWER_DEPTH] <= route_answer(item);
				answers_issued <= answers_issued + 1;
				gap_left        = pick_gap();
			end
			if (start && !taken) begin
				// block still busy: hold the request as is
			end else if (gap_left > 0 || stimulus.size() == 0 ||
					(stimulus[0].drain_first &&
					answers_checked != answers_issued + (taken ? 1 : 0))) begin
				if (gap_left > 0)
					gap_left--;
				start <= 1'b0;
				item  <= random_item();
			end else begin
				start <= 1'b1;
				item  <= stimulus[0].payload;
				stimulus.delete(0);
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: every done pulse is one result transfer
	// ---------------------------------------------------------------
	task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch on answer %0d, %s: expected %0d, got %0d",
				answers_checked, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : check_answers
		result_t want;
		if (!arst_n) begin
			answers_checked <= 0;
		end else if (done) begin
			if (answers_checked == answers_issued) begin
				flag_mismatch("unexpected result", 0, 1);
			end else begin
				want = expected_answers[answers_checked % ANSWER_DEPTH];
				if (result.found !== want.found)
					flag_mismatch("found", want.found, result.found);
				if (result.result_slot !== want.result_slot)
					flag_mismatch("result_slot", want.result_slot, result.result_slot);
				answers_checked <= answers_checked + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d answers seen",
				cycle_count, answers_checked, answers_issued);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus plan, reset and end of run
	// ---------------------------------------------------------------
	initial begin : plan_and_run
		req_kind_t query_kinds[3];
		int        colx[5];
		int        rowy[5];
		int        lx[MAX_RECTS];
		int        ly[MAX_RECTS];
		int        lw[MAX_RECTS];
		int        lh[MAX_RECTS];
		int        laid[MAX_RECTS];
		int        n_laid;
		int        x0;
		int        y0;
		int        slot;
		int        c;
		int        r;
		int        k;
		int        px;
		int        py;
		int        directed_count;
		bit        drain;
		bit        drained_once;
		item_t     it;

		query_kinds = '{REQ_CONTAIN, REQ_NEIGHBOR, REQ_WRAP};

		// directed: a cross of rectangles around slot 2, one huge and one empty
		// rectangle at the coordinate extremes, and a duplicate of slot 2 for ties
		queue_item(make_write(0, -32768, -32768, 65535, 65535), 1'b0);
		queue_item(make_write(1, 32767, 32767, 0, 0), 1'b0);
		queue_item(make_write(2, 0, 0, 100, 50), 1'b0);
		queue_item(make_write(3, 100, 0, 60, 50), 1'b0);
		queue_item(make_write(4, 0, 50, 100, 40), 1'b0);
		queue_item(make_write(5, -80, 0, 80, 50), 1'b0);
		queue_item(make_write(6, 0, -30, 100, 30), 1'b0);
		queue_item(make_write(7, 0, 0, 100, 50), 1'b0);
		queue_item(make_query(REQ_CONTAIN, 0, 50, 25, DIR_TOP), 1'b0);
		queue_item(make_query(REQ_CONTAIN, 0, 32767, 32767, DIR_LEFT), 1'b0);
		queue_item(make_query(REQ_CONTAIN, 0, -32768, -32768, DIR_BOTTOM), 1'b0);
		queue_item(make_query(REQ_NEIGHBOR, 2, 0, 25, DIR_RIGHT), 1'b0);
		queue_item(make_query(REQ_NEIGHBOR, 2, 0, 49, DIR_LEFT), 1'b0);
		queue_item(make_query(REQ_NEIGHBOR, 2, 99, 0, DIR_BOTTOM), 1'b0);
		queue_item(make_query(REQ_NEIGHBOR, 2, -5, 0, DIR_TOP), 1'b0);
		// slots 2 and 7 tie on the metric: the later slot wins
		queue_item(make_query(REQ_NEIGHBOR, 4, 50, 0, DIR_TOP), 1'b0);
		queue_item(make_query(REQ_WRAP, 0, 50, 0, DIR_TOP), 1'b0);
		queue_item(make_query(REQ_WRAP, 0, -32768, 0, DIR_BOTTOM), 1'b0);
		queue_item(make_query(REQ_WRAP, 0, 0, 25, DIR_LEFT), 1'b0);
		queue_item(make_query(REQ_WRAP, 0, 0, -32768, DIR_RIGHT), 1'b0);
		it          = random_item();
		it.req_type = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
		queue_item(it, 1'b0);
		// empty table, then a neighbor query from a source that is no longer valid
		queue_item(make_query(REQ_CLEAR, 0, 0, 0, DIR_TOP), 1'b0);
		queue_item(make_query(REQ_CONTAIN, 0, 50, 25, DIR_TOP), 1'b0);
		queue_item(make_query(REQ_WRAP, 0, 0, 0, DIR_BOTTOM), 1'b0);
		queue_item(make_query(REQ_NEIGHBOR, 3, 0, 25, DIR_RIGHT), 1'b0);
		directed_count = stimulus.size();

		// random part: mostly tiled layouts so that edges really touch,
		// with queries aimed at and around the laid rectangles
		drained_once = 1'b0;
		while (stimulus.size() < directed_count + RANDOM_ITEMS) begin
			drain        = !drained_once || ($urandom_range(0, 9) == 0);
			drained_once = 1'b1;
			if ($urandom_range(0, 9) < 8) begin
				x0 = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 62000)) - 32768
					: int'($urandom_range(0, 4000)) - 2000;
				y0 = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 62000)) - 32768
					: int'($urandom_range(0, 4000)) - 2000;
				colx[0] = x0;
				rowy[0] = y0;
				for (int i = 0; i < 4; i++) begin
					colx[i+1] = colx[i] + (($urandom_range(0, 9) == 0) ? 1
						: int'($urandom_range(1, 300)));
					rowy[i+1] = rowy[i] + (($urandom_range(0, 9) == 0) ? 1
						: int'($urandom_range(1, 300)));
				end
				if ($urandom_range(0, 1) == 1) begin
					queue_item(make_query(REQ_CLEAR, 0, 0, 0, DIR_TOP), drain);
					drain = 1'b0;
				end
				n_laid = $urandom_range(2, MAX_RECTS);
				for (int n = 0; n < n_laid; n++) begin
					slot    = $urandom_range(0, MAX_RECTS - 1);
					laid[n] = slot;
					c       = $urandom_range(0, 3);
					r       = $urandom_range(0, 3);
					lx[slot] = colx[c];
					ly[slot] = rowy[r];
					// one or two grid cells wide and tall
					lw[slot] = colx[(c < 3) ? c + $urandom_range(1, 2) : 4] - colx[c];
					lh[slot] = rowy[(r < 3) ? r + $urandom_range(1, 2) : 4] - rowy[r];
					// sometimes break the tiling or make an empty rectangle
					case ($urandom_range(0, 19))
						0:       lw[slot] = 0;
						1:       lw[slot] = lw[slot] + 1;
						2:       lh[slot] = 0;
						3:       lh[slot] = lh[slot] + 1;
						default: ;
					endcase
					queue_item(make_write(slot, lx[slot], ly[slot], lw[slot], lh[slot]), drain);
					drain = 1'b0;
				end
				for (int q = $urandom_range(4, 14); q > 0; q--) begin
					k = laid[$urandom_range(0, n_laid - 1)];
					case ($urandom_range(0, 5))
						0:       px = lx[k] + ((lw[k] > 0) ? int'($urandom_range(0, lw[k] - 1)) : 0);
						1:       px = lx[k] - 1;
						2:       px = lx[k] + lw[k] - 1;
						3:       px = lx[k] + lw[k];
						4:       px = lx[k];
						default: px = int'(16'($urandom));
					endcase
					case ($urandom_range(0, 5))
						0:       py = ly[k] + ((lh[k] > 0) ? int'($urandom_range(0, lh[k] - 1)) : 0);
						1:       py = ly[k] - 1;
						2:       py = ly[k] + lh[k] - 1;
						3:       py = ly[k] + lh[k];
						4:       py = ly[k];
						default: py = int'(16'($urandom));
					endcase
					// every slot has been written once, so any source is fair
					if ($urandom_range(0, 4) == 0)
						k = $urandom_range(0, MAX_RECTS - 1);
					queue_item(make_query(query_kinds[$urandom_range(0, 2)], k, px, py,
						dir_t'(2'($urandom_range(0, 3)))), 1'b0);
				end
			end else begin
				// noise: raw items of any kind, spare kinds included
				for (int n = $urandom_range(1, 4); n > 0; n--) begin
					queue_item(random_item(), drain);
					drain = 1'b0;
				end
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// all requests transferred, then all answers in, then a quiet tail
		while (stimulus.size() != 0 || start)
			@(posedge clk);
		while (answers_checked != answers_issued)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
